[rtl/core/deq_pkg.sv]
// deq_pkg: shared constants, codes, command/status structs and ring index helpers
// for the double-ended queue; no dependencies
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int MODE_W   = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int EMIT_W   = 3;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_LIST       = MODE_W'(4);

    localparam logic [STATUS_W-1:0] STATUS_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_FULL  = STATUS_W'(2);

    localparam logic [EMIT_W-1:0] EMIT_NONE  = EMIT_W'(0);
    localparam logic [EMIT_W-1:0] EMIT_OK    = EMIT_W'(1);
    localparam logic [EMIT_W-1:0] EMIT_EMPTY = EMIT_W'(2);
    localparam logic [EMIT_W-1:0] EMIT_FULL  = EMIT_W'(3);
    localparam logic [EMIT_W-1:0] EMIT_DATA  = EMIT_W'(4);

    typedef struct packed {
        logic              load;
        logic              push_wr;
        logic              pop_rd;
        logic              list_rd;
        logic              list_first;
        logic [EMIT_W-1:0] emit;
        logic              last;
    } t_dp_cmd;

    typedef struct packed {
        logic is_push;
        logic is_pop;
        logic is_list;
        logic empty;
        logic full;
        logic list_done;
    } t_dp_status;

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] offs);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(offs);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] base);
        logic [IDX_W-1:0] res;
        if (base == '0) begin
            res = IDX_W'(DEPTH - 1);
        end else begin
            res = base - 1'b1;
        end
        return res;
    endfunction

endpackage

[rtl/core/deq_ctrl.sv]
// deq_ctrl: controller state machine for the double-ended queue
// depends on deq_pkg (command and status structs, emit codes)
`timescale 1ns / 1ps

module deq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  deq_pkg::t_dp_status i_status,
    output deq_pkg::t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_POP  = 2'd2;
    localparam logic [1:0] S_LIST = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.emit       = deq_pkg::EMIT_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                if (i_status.is_push) begin
                    o_cmd.last = 1'b1;
                    if (i_status.full) begin
                        o_cmd.emit = deq_pkg::EMIT_FULL;
                    end else begin
                        o_cmd.push_wr = 1'b1;
                        o_cmd.emit    = deq_pkg::EMIT_OK;
                    end
                end else if (i_status.is_pop || i_status.is_list) begin
                    if (i_status.empty) begin
                        o_cmd.emit = deq_pkg::EMIT_EMPTY;
                        o_cmd.last = 1'b1;
                    end else if (i_status.is_pop) begin
                        o_cmd.pop_rd = 1'b1;
                        n_state      = S_POP;
                    end else begin
                        o_cmd.list_rd    = 1'b1;
                        o_cmd.list_first = 1'b1;
                        n_state          = S_LIST;
                    end
                end
            end
            S_POP: begin
                o_cmd.emit = deq_pkg::EMIT_DATA;
                o_cmd.last = 1'b1;
                n_state    = S_IDLE;
            end
            S_LIST: begin
                o_cmd.emit = deq_pkg::EMIT_DATA;
                o_cmd.last = i_status.list_done;
                if (i_status.list_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.list_rd = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/deq_datapath.sv]
// deq_datapath: ring buffer memory, front pointer, occupancy, list cursor, result register
// depends on deq_pkg (sizes, codes, structs, ring index helpers)
`timescale 1ns / 1ps

module deq_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic [deq_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [deq_pkg::VALUE_W-1:0]  i_value,
    input  deq_pkg::t_dp_cmd                    i_cmd,
    output deq_pkg::t_dp_status                 o_status_flags,
    output logic                                o_valid,
    output logic [deq_pkg::STATUS_W-1:0]        o_status,
    output logic signed [deq_pkg::VALUE_W-1:0]  o_value_res,
    output logic                                o_is_last
);

    logic [deq_pkg::VALUE_W-1:0] r_mem [deq_pkg::DEPTH];

    logic [deq_pkg::MODE_W-1:0]   r_mode;
    logic [deq_pkg::VALUE_W-1:0]  r_value;
    logic [deq_pkg::IDX_W-1:0]    r_front;
    logic [deq_pkg::IDX_W-1:0]    n_front;
    logic [deq_pkg::CNT_W-1:0]    r_count;
    logic [deq_pkg::CNT_W-1:0]    n_count;
    logic [deq_pkg::CNT_W-1:0]    r_list_idx;
    logic [deq_pkg::CNT_W-1:0]    n_list_idx;
    logic [deq_pkg::VALUE_W-1:0]  r_rd_data;
    logic [deq_pkg::IDX_W-1:0]    wr_addr;
    logic [deq_pkg::IDX_W-1:0]    rd_addr;
    logic                         at_front;

    logic                         r_valid;
    logic [deq_pkg::STATUS_W-1:0] r_status;
    logic [deq_pkg::VALUE_W-1:0]  r_res;
    logic                         r_last;

    assign at_front = (r_mode == deq_pkg::MODE_PUSH_FRONT) ||
                      (r_mode == deq_pkg::MODE_POP_FRONT);

    assign o_status_flags.is_push   = (r_mode == deq_pkg::MODE_PUSH_FRONT) ||
                                      (r_mode == deq_pkg::MODE_PUSH_BACK);
    assign o_status_flags.is_pop    = (r_mode == deq_pkg::MODE_POP_FRONT) ||
                                      (r_mode == deq_pkg::MODE_POP_BACK);
    assign o_status_flags.is_list   = (r_mode == deq_pkg::MODE_LIST);
    assign o_status_flags.empty     = (r_count == '0);
    assign o_status_flags.full      = (r_count == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign o_status_flags.list_done = (r_list_idx == r_count);

    always_comb begin
        if (at_front) begin
            wr_addr = deq_pkg::wrap_dec(r_front);
        end else begin
            wr_addr = deq_pkg::wrap_add(r_front, r_count);
        end

        if (i_cmd.list_rd) begin
            rd_addr = deq_pkg::wrap_add(r_front, i_cmd.list_first ? '0 : r_list_idx);
        end else if (at_front) begin
            rd_addr = r_front;
        end else begin
            rd_addr = deq_pkg::wrap_add(r_front, r_count - 1'b1);
        end

        n_front    = r_front;
        n_count    = r_count;
        n_list_idx = r_list_idx;
        if (i_cmd.push_wr) begin
            n_count = r_count + 1'b1;
            if (at_front) begin
                n_front = wr_addr;
            end
        end
        if (i_cmd.pop_rd) begin
            n_count = r_count - 1'b1;
            if (at_front) begin
                n_front = deq_pkg::wrap_add(r_front, deq_pkg::CNT_W'(1));
            end
        end
        if (i_cmd.list_rd) begin
            n_list_idx = i_cmd.list_first ? deq_pkg::CNT_W'(1) : r_list_idx + 1'b1;
        end
    end

    // ring storage, one write or one read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.push_wr) begin
            r_mem[wr_addr] <= r_value;
        end
        if (i_cmd.pop_rd || i_cmd.list_rd) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_value <= i_value;
        end
        r_last <= i_cmd.last;
        case (i_cmd.emit)
            deq_pkg::EMIT_EMPTY: begin
                r_status <= deq_pkg::STATUS_EMPTY;
                r_res    <= '0;
            end
            deq_pkg::EMIT_FULL: begin
                r_status <= deq_pkg::STATUS_FULL;
                r_res    <= '0;
            end
            deq_pkg::EMIT_DATA: begin
                r_status <= deq_pkg::STATUS_OK;
                r_res    <= r_rd_data;
            end
            default: begin
                r_status <= deq_pkg::STATUS_OK;
                r_res    <= '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front    <= '0;
            r_count    <= '0;
            r_list_idx <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_front    <= n_front;
            r_count    <= n_count;
            r_list_idx <= n_list_idx;
            r_valid    <= (i_cmd.emit != deq_pkg::EMIT_NONE);
        end
    end

    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_value_res = r_res;
    assign o_is_last   = r_last;

endmodule

[rtl/core/double_ended_queue_top.sv]
// double_ended_queue_top: bounded double-ended queue of signed 32-bit values
// push and empty/full reports pass through the S_EXEC state, pops through S_EXEC (registered ring read) and S_POP
// busy stays high until the controller is back in S_IDLE, so a new transaction waits for the previous one to finish
// a listing streams one stored value per cycle, paced by the registered ring memory read
// reset (synchronous, active low) empties the queue; results cannot be stalled by the receiver
`timescale 1ns / 1ps

module double_ended_queue_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [deq_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [deq_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    output logic [deq_pkg::STATUS_W-1:0]        o_status,
    output logic signed [deq_pkg::VALUE_W-1:0]  o_value_res,
    output logic                                o_is_last
);

    deq_pkg::t_dp_cmd    cmd;
    deq_pkg::t_dp_status flags;

    deq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .o_busy   (busy),
        .i_status (flags),
        .o_cmd    (cmd)
    );

    deq_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_mode         (i_mode),
        .i_value        (i_value),
        .i_cmd          (cmd),
        .o_status_flags (flags),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_value_res    (o_value_res),
        .o_is_last      (o_is_last)
    );

    a_no_result_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_valid)
        else $error("result right after an accepted transaction");

    a_list_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_last) |=> o_valid)
        else $error("listing stream broken");

    a_idle_result_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && o_valid) |-> o_is_last)
        else $error("non-final result while idle");

    a_error_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != deq_pkg::STATUS_OK) |-> (o_is_last && o_value_res == '0))
        else $error("empty or full report malformed");

    a_one_mem_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({cmd.push_wr, cmd.pop_rd, cmd.list_rd}) <= 1)
        else $error("more than one ring access in a cycle");

endmodule
